// ----- hw/rtl/tlnf_pkg.sv -----
`timescale 1ns / 1ps

package tlnf_pkg;

  localparam int NumberDigits = 6;
  localparam int CapDigits    = 6;
  localparam int QueueDepth   = 2;

  localparam int ByteW    = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;
  localparam int ExpLenW  = 3;
  localparam int ExpChars = 4;
  localparam int BcdW     = 4;

  localparam logic [ByteW-1:0] CharNl     = 8'h0A;
  localparam logic [ByteW-1:0] CharTab    = 8'h09;
  localparam logic [ByteW-1:0] CharSpace  = 8'h20;
  localparam logic [ByteW-1:0] CharZero   = 8'h30;
  localparam logic [ByteW-1:0] CharCaret  = 8'h5E;
  localparam logic [ByteW-1:0] CharQuery  = 8'h3F;
  localparam logic [ByteW-1:0] CharM      = 8'h4D;
  localparam logic [ByteW-1:0] CharDash   = 8'h2D;
  localparam logic [ByteW-1:0] CharI      = 8'h49;
  localparam logic [ByteW-1:0] CharDollar = 8'h24;
  localparam logic [ByteW-1:0] CharDel    = 8'h7F;
  localparam logic [ByteW-1:0] CtrlLimit  = 8'd32;
  localparam logic [ByteW-1:0] CaretShift = 8'd64;
  localparam logic [ByteW-1:0] HighCtrlLo = 8'd128;
  localparam logic [ByteW-1:0] HighCtrlHi = 8'd159;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NUMBER_MODE      = 3'd0,
    REG_SQUEEZE_BLANK    = 3'd1,
    REG_SHOW_ENDS        = 3'd2,
    REG_SHOW_TABS        = 3'd3,
    REG_SHOW_NONPRINTING = 3'd4
  } tlnf_reg_e;

  typedef enum logic [1:0] {
    NUM_OFF       = 2'd0,
    NUM_ALL       = 2'd1,
    NUM_NONBLANK  = 2'd2,
    NUM_NONBLANK2 = 2'd3
  } tlnf_num_e;

  typedef struct packed {
    logic                           num;
    logic [ExpLenW-1:0]             exp_len;
    logic [ExpChars-1:0][ByteW-1:0] exp_char;
  } tlnf_desc_t;

endpackage

// ----- hw/rtl/tlnf_in_if.sv -----
`timescale 1ns / 1ps

interface tlnf_in_if import tlnf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             file_start;

  modport source(output valid, in_byte, file_start, input ready);
  modport sink(input valid, in_byte, file_start, output ready);
endinterface

// ----- hw/rtl/tlnf_out_if.sv -----
`timescale 1ns / 1ps

interface tlnf_out_if import tlnf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_char;
  logic             last;

  modport source(output valid, out_char, last, input ready);
  modport sink(input valid, out_char, last, output ready);
endinterface

// ----- hw/rtl/tlnf_cfg_if.sv -----
`timescale 1ns / 1ps

interface tlnf_cfg_if import tlnf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wr_data;

  modport source(output valid, reg_index, wr_data, input ready);
  modport sink(input valid, reg_index, wr_data, output ready);
endinterface

// ----- hw/rtl/tlnf_front.sv -----
`timescale 1ns / 1ps

module tlnf_front import tlnf_pkg::*; #(
  parameter int NUMBER_DIGITS = NumberDigits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tlnf_in_if.sink                             in_i,
  tlnf_cfg_if.sink                            cfg_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output tlnf_desc_t                          push_desc_o,
  output logic [NUMBER_DIGITS-1:0][BcdW-1:0]  push_digits_o
);

  localparam int SatDigits = (NUMBER_DIGITS < CapDigits) ? NUMBER_DIGITS : CapDigits;

  logic [1:0] number_mode_q;
  logic       squeeze_q, ends_q, tabs_q, nonprint_q;

  logic after_nl_q, after_nl_d;
  logic squeezing_q, squeezing_d;
  logic [NUMBER_DIGITS-1:0][BcdW-1:0] digits_q, digits_d;

  logic [ByteW-1:0] c;
  logic             is_nl;
  logic             an, sq, drop, num, sat, carry, accept;
  logic [NUMBER_DIGITS-1:0][BcdW-1:0] digits_cur, digits_inc;
  tlnf_desc_t       desc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_mode_q <= NUM_OFF;
      squeeze_q     <= 1'b0;
      ends_q        <= 1'b0;
      tabs_q        <= 1'b0;
      nonprint_q    <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_NUMBER_MODE:      number_mode_q <= cfg_i.wr_data[1:0];
        REG_SQUEEZE_BLANK:    squeeze_q     <= cfg_i.wr_data[0];
        REG_SHOW_ENDS:        ends_q        <= cfg_i.wr_data[0];
        REG_SHOW_TABS:        tabs_q        <= cfg_i.wr_data[0];
        REG_SHOW_NONPRINTING: nonprint_q    <= cfg_i.wr_data[0];
        default: ;
      endcase
    end
  end

  assign c      = in_i.in_byte;
  assign is_nl  = (c == CharNl);
  assign accept = in_i.valid && push_ready_i;

  always_comb begin
    an         = in_i.file_start ? 1'b1 : after_nl_q;
    sq         = in_i.file_start ? 1'b0 : squeezing_q;
    digits_cur = in_i.file_start ? '0 : digits_q;
    drop        = 1'b0;
    squeezing_d = sq;
    if (an && squeeze_q) begin
      if (is_nl) begin
        if (sq) begin
          drop = 1'b1;
        end else begin
          squeezing_d = 1'b1;
        end
      end else begin
        squeezing_d = 1'b0;
      end
    end
    num = an && !drop && (number_mode_q != NUM_OFF) &&
          ((number_mode_q == NUM_ALL) || !is_nl);

    sat = 1'b1;
    for (int i = 0; i < SatDigits; i++) begin
      if (digits_cur[i] != BcdW'(9)) begin
        sat = 1'b0;
      end
    end
    carry = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry && digits_cur[i] == BcdW'(9)) begin
        digits_inc[i] = '0;
      end else begin
        digits_inc[i] = digits_cur[i] + BcdW'(carry);
        carry         = 1'b0;
      end
    end
    digits_d   = (num && !sat) ? digits_inc : digits_cur;
    after_nl_d = is_nl;

    desc.num      = num;
    desc.exp_len  = ExpLenW'(1);
    desc.exp_char = '0;
    desc.exp_char[0] = c;
    if (!is_nl && (c != CharTab) && nonprint_q) begin
      if (c < CtrlLimit) begin
        desc.exp_len     = ExpLenW'(2);
        desc.exp_char[0] = CharCaret;
        desc.exp_char[1] = c + CaretShift;
      end else if (c == CharDel) begin
        desc.exp_len     = ExpLenW'(2);
        desc.exp_char[0] = CharCaret;
        desc.exp_char[1] = CharQuery;
      end else if (c >= HighCtrlLo && c <= HighCtrlHi) begin
        desc.exp_len     = ExpLenW'(4);
        desc.exp_char[0] = CharM;
        desc.exp_char[1] = CharDash;
        desc.exp_char[2] = CharCaret;
        desc.exp_char[3] = c - CaretShift;
      end
    end else if (ends_q && is_nl) begin
      desc.exp_len     = ExpLenW'(2);
      desc.exp_char[0] = CharDollar;
      desc.exp_char[1] = CharNl;
    end else if (tabs_q && (c == CharTab)) begin
      desc.exp_len     = ExpLenW'(2);
      desc.exp_char[0] = CharCaret;
      desc.exp_char[1] = CharI;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_nl_q  <= 1'b1;
      squeezing_q <= 1'b0;
      digits_q    <= '0;
    end else if (accept) begin
      after_nl_q  <= after_nl_d;
      squeezing_q <= squeezing_d;
      digits_q    <= digits_d;
    end
  end

  assign in_i.ready    = push_ready_i;
  assign push_valid_o  = in_i.valid && !drop;
  assign push_desc_o   = desc;
  assign push_digits_o = digits_d;

endmodule

// ----- hw/rtl/tlnf_queue.sv -----
`timescale 1ns / 1ps

module tlnf_queue import tlnf_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/tlnf_back.sv -----
`timescale 1ns / 1ps

module tlnf_back import tlnf_pkg::*; #(
  parameter int NUMBER_DIGITS = NumberDigits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               head_valid_i,
  input  tlnf_desc_t                         head_desc_i,
  input  logic [NUMBER_DIGITS-1:0][BcdW-1:0] head_digits_i,
  output logic                               pop_o,
  tlnf_out_if.source                         out_o
);

  localparam int IdxW = $clog2(NUMBER_DIGITS + 6);

  logic [IdxW-1:0]  idx_q, idx_d;
  logic             lead_q, lead_d;
  logic             out_valid_q;
  logic [ByteW-1:0] out_char_q;
  logic             out_last_q;

  logic             advance, in_digits, in_tab, is_last;
  logic [IdxW-1:0]  base, eoff;
  logic [BcdW-1:0]  dig;
  logic [ByteW-1:0] ch;

  assign advance = head_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    base      = head_desc_i.num ? IdxW'(NUMBER_DIGITS + 1) : '0;
    eoff      = idx_q - base;
    in_digits = head_desc_i.num && (idx_q < IdxW'(NUMBER_DIGITS));
    in_tab    = head_desc_i.num && (idx_q == IdxW'(NUMBER_DIGITS));
    dig = '0;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (idx_q == IdxW'(NUMBER_DIGITS - 1 - i)) begin
        dig = head_digits_i[i];
      end
    end
    lead_d  = lead_q;
    is_last = 1'b0;
    if (in_digits) begin
      lead_d = lead_q && (dig == '0);
      if (lead_q && (dig == '0) && (idx_q < IdxW'(NUMBER_DIGITS - 1))) begin
        ch = CharSpace;
      end else begin
        ch = CharZero + ByteW'(dig);
      end
    end else if (in_tab) begin
      ch = CharTab;
    end else begin
      ch      = head_desc_i.exp_char[eoff[1:0]];
      is_last = (eoff == IdxW'(head_desc_i.exp_len) - IdxW'(1));
    end
    idx_d = is_last ? '0 : idx_q + IdxW'(1);
  end

  assign pop_o = advance && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      lead_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        idx_q       <= idx_d;
        lead_q      <= is_last ? 1'b1 : lead_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_char_q <= ch;
      out_last_q <= is_last;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.last     = out_last_q;

endmodule

// ----- hw/rtl/text_line_number_visible_filter_top.sv -----
`timescale 1ns / 1ps

// Formats a byte stream like cat with its numbering, squeeze and show options. The front end
// takes one byte per cycle whenever its two-entry descriptor queue has room, updates the
// line state and decides the expansion; squeezed newlines are dropped there and give no
// output. The back end sends one character per cycle from its output register while the
// receiver is ready. A byte produces 1 character for plain text, 2 for caret forms or shown
// ends, 4 for M-^ forms, plus NUMBER_DIGITS + 1 when a line number is prefixed. A byte's
// descriptor is registered in the descriptor queue and its characters then in the output
// register. Configuration is taken at any time and should be written while the block is idle.
module text_line_number_visible_filter_top import tlnf_pkg::*; #(
  parameter int NUMBER_DIGITS = NumberDigits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlnf_in_if.sink     in_i,
  tlnf_cfg_if.sink    cfg_i,
  tlnf_out_if.source  out_o
);

  localparam int DescW = $bits(tlnf_desc_t) + NUMBER_DIGITS * BcdW;

  logic                               f_valid, f_ready;
  tlnf_desc_t                         f_desc;
  logic [NUMBER_DIGITS-1:0][BcdW-1:0] f_digits;
  logic                               q_valid, q_pop;
  logic [DescW-1:0]                   q_data;
  tlnf_desc_t                         h_desc;
  logic [NUMBER_DIGITS-1:0][BcdW-1:0] h_digits;

  tlnf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .cfg_i         (cfg_i),
    .push_valid_o  (f_valid),
    .push_ready_i  (f_ready),
    .push_desc_o   (f_desc),
    .push_digits_o (f_digits)
  );

  tlnf_queue #(
    .Width(DescW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_desc, f_digits}),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_data)
  );

  assign {h_desc, h_digits} = q_data;

  tlnf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_valid),
    .head_desc_i   (h_desc),
    .head_digits_i (h_digits),
    .pop_o         (q_pop),
    .out_o         (out_o)
  );

`ifndef SYNTHESIS
  a_expand_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last |=> out_o.valid)
    else $error("gap inside the expansion of one byte");

  a_queue_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && (!out_o.valid || out_o.ready) |=> out_o.valid)
    else $error("queued byte not moved to output");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_o.valid && out_o.last)
    else $error("descriptor released without final character");
`endif

endmodule

// ----- tb/text_line_number_visible_filter_top_test.sv -----
`timescale 1ns / 1ps

module text_line_number_visible_filter_top_test;
  import tlnf_pkg::*;

  localparam int LineCap    = (NumberDigits >= 6) ? 999999 : (10 ** NumberDigits) - 1;
  localparam int IdlePct    = 23;
  localparam int HoldAt     = 110;
  localparam int HoldCycles = 300;
  localparam int SettleGap  = 10;
  localparam int CycleLimit = 300000;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             fs;
  } text_byte_t;

  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             last;
  } shown_char_t;

  logic clk_i;
  logic rst_ni;

  tlnf_in_if  in_bus ();
  tlnf_cfg_if cfg_bus ();
  tlnf_out_if out_bus ();

  text_line_number_visible_filter_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .cfg_i (cfg_bus),
    .out_o (out_bus)
  );

  text_byte_t  text_queue[$];
  shown_char_t expected_chars[$];

  tlnf_num_e   num_mode;
  logic        squeeze_on;
  logic        ends_on;
  logic        tabs_on;
  logic        nonprint_on;
  logic        at_line_start;
  logic        squeezing_blank;
  logic [19:0] line_count;

  int          bytes_taken;
  int          mismatches;
  int          cycle_count;
  int          hold_left;
  logic        hold_done;
  logic        no_gaps;

  // formatted characters for one byte, in order, last flag on the final one
  function automatic void format_byte(input logic [ByteW-1:0] b, input logic fs);
    logic [ByteW-1:0] chars[$];
    logic [ByteW-1:0] digits[NumberDigits];
    logic [19:0]      v;
    int               i;
    if (fs) begin
      at_line_start   = 1'b1;
      squeezing_blank = 1'b0;
      line_count      = '0;
    end
    if (at_line_start) begin
      if (squeeze_on) begin
        if (b == CharNl) begin
          if (squeezing_blank) return;
          squeezing_blank = 1'b1;
        end else begin
          squeezing_blank = 1'b0;
        end
      end
      if (num_mode != NUM_OFF && (num_mode == NUM_ALL || b != CharNl)) begin
        if (line_count < LineCap) line_count = line_count + 1'b1;
        v = line_count;
        for (i = NumberDigits - 1; i >= 0; i--) begin
          digits[i] = CharZero + ByteW'(v % 10);
          v = v / 20'd10;
        end
        for (i = 0; i < NumberDigits - 1 && digits[i] == CharZero; i++) begin
          digits[i] = CharSpace;
        end
        for (i = 0; i < NumberDigits; i++) chars.push_back(digits[i]);
        chars.push_back(CharTab);
      end
    end
    at_line_start = (b == CharNl);

    if (b != CharNl && b != CharTab && nonprint_on) begin
      if (b < CtrlLimit) begin
        chars.push_back(CharCaret);
        chars.push_back(b + CaretShift);
      end else if (b == CharDel) begin
        chars.push_back(CharCaret);
        chars.push_back(CharQuery);
      end else if (b >= HighCtrlLo && b <= HighCtrlHi) begin
        chars.push_back(CharM);
        chars.push_back(CharDash);
        chars.push_back(CharCaret);
        chars.push_back(b - CaretShift);
      end else begin
        chars.push_back(b);
      end
    end else if (ends_on && b == CharNl) begin
      chars.push_back(CharDollar);
      chars.push_back(b);
    end else if (tabs_on && b == CharTab) begin
      chars.push_back(CharCaret);
      chars.push_back(CharI);
    end else begin
      chars.push_back(b);
    end

    foreach (chars[k]) expected_chars.push_back('{ch: chars[k], last: k == chars.size() - 1});
  endfunction

  function automatic logic [ByteW-1:0] random_text_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return CharNl;
    if (roll < 35) return CharTab;
    if (roll < 45) return ByteW'($urandom_range(0, 31));
    if (roll < 50) return CharDel;
    if (roll < 60) return ByteW'($urandom_range(128, 159));
    if (roll < 70) return ByteW'($urandom_range(160, 255));
    return ByteW'($urandom_range(32, 126));
  endfunction

  function automatic void add_byte(input logic fs, input logic [ByteW-1:0] b);
    text_queue.push_back('{b: b, fs: fs});
  endfunction

  function automatic void add_random_text(input int count);
    for (int i = 0; i < count; i++) begin
      add_byte($urandom_range(0, 99) < 4, random_text_byte());
    end
  endfunction

  // valid stays high across back-to-back writes, caller lowers it
  task automatic put_reg(input tlnf_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wr_data   <= val;
    do @(posedge clk_i); while (!(cfg_bus.valid && cfg_bus.ready));
    case (idx)
      REG_NUMBER_MODE:      num_mode    = tlnf_num_e'(val[1:0]);
      REG_SQUEEZE_BLANK:    squeeze_on  = val[0];
      REG_SHOW_ENDS:        ends_on     = val[0];
      REG_SHOW_TABS:        tabs_on     = val[0];
      REG_SHOW_NONPRINTING: nonprint_on = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input tlnf_num_e mode, input logic sq, input logic ends,
                                input logic tabs, input logic np);
    put_reg(REG_NUMBER_MODE, CfgDataW'(mode));
    put_reg(REG_SQUEEZE_BLANK, CfgDataW'(sq));
    put_reg(REG_SHOW_ENDS, CfgDataW'(ends));
    put_reg(REG_SHOW_TABS, CfgDataW'(tabs));
    put_reg(REG_SHOW_NONPRINTING, CfgDataW'(np));
    cfg_bus.valid <= 1'b0;
  endtask

  // a squeezed newline gives no output, so allow the pipe to settle after the last char
  task automatic drain();
    do @(posedge clk_i);
    while (text_queue.size() != 0 || in_bus.valid || expected_chars.size() != 0);
    repeat (SettleGap) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : feed
    text_byte_t item;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        format_byte(in_bus.in_byte, in_bus.file_start);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (text_queue.size() != 0 && (no_gaps || $urandom_range(0, 99) >= IdlePct)) begin
          item = text_queue.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.in_byte    <= item.b;
          in_bus.file_start <= item.fs;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin : collect
    shown_char_t want;
    int          errs;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      errs = 0;
      if (out_bus.valid && out_bus.ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected transfer: out_char %h last %b", out_bus.out_char, out_bus.last);
          errs = errs + 1;
        end else begin
          want = expected_chars.pop_front();
          if (out_bus.out_char !== want.ch) begin
            $error("out_char mismatch: expected %h, got %h", want.ch, out_bus.out_char);
            errs = errs + 1;
          end
          if (out_bus.last !== want.last) begin
            $error("last mismatch: expected %b, got %b", want.last, out_bus.last);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0) begin
        mismatches <= mismatches + errs;
      end
      if (!hold_done && bytes_taken >= HoldAt) begin
        hold_done     <= 1'b1;
        hold_left     <= HoldCycles;
        out_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= no_gaps || $urandom_range(0, 99) >= IdlePct;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.in_byte    = '0;
    in_bus.file_start = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.reg_index = REG_NUMBER_MODE;
    cfg_bus.wr_data   = '0;
    out_bus.ready     = 1'b0;
    num_mode          = NUM_OFF;
    squeeze_on        = 1'b0;
    ends_on           = 1'b0;
    tabs_on           = 1'b0;
    nonprint_on       = 1'b0;
    at_line_start     = 1'b1;
    squeezing_blank   = 1'b0;
    line_count        = '0;
    bytes_taken       = 0;
    mismatches        = 0;
    cycle_count       = 0;
    hold_left         = 0;
    hold_done         = 1'b0;
    no_gaps           = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every option on: all control classes, tab, blank runs, file restart
    apply_settings(NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
    add_byte(1'b1, "a");
    add_byte(1'b0, 8'h00);
    add_byte(1'b0, 8'h1F);
    add_byte(1'b0, CharDel);
    add_byte(1'b0, 8'h80);
    add_byte(1'b0, 8'h9F);
    add_byte(1'b0, 8'hA0);
    add_byte(1'b0, 8'hFF);
    add_byte(1'b0, CharSpace);
    add_byte(1'b0, CharTab);
    add_byte(1'b0, CharNl);
    add_byte(1'b0, CharNl);
    add_byte(1'b0, CharNl);
    add_byte(1'b0, CharNl);
    add_byte(1'b0, "b");
    add_byte(1'b0, CharNl);
    add_byte(1'b1, CharNl);
    add_byte(1'b0, CharNl);
    drain();

    // mode three numbers non-blank lines, squeeze state held while squeeze is off
    apply_settings(NUM_NONBLANK2, 1'b0, 1'b0, 1'b0, 1'b0);
    add_byte(1'b0, CharNl);
    add_byte(1'b0, "x");
    add_byte(1'b0, CharNl);
    add_byte(1'b0, CharNl);
    add_byte(1'b0, CharTab);
    add_byte(1'b0, 8'h00);
    add_byte(1'b0, 8'h80);
    add_byte(1'b0, CharNl);
    drain();

    apply_settings(NUM_OFF, 1'b0, 1'b0, 1'b0, 1'b0);
    add_random_text(25);
    drain();

    no_gaps <= 1'b1;
    apply_settings(NUM_NONBLANK, 1'b1, 1'b1, 1'b1, 1'b1);
    add_random_text(40);
    drain();
    no_gaps <= 1'b0;

    // receiver holds off partway through this phase
    apply_settings(NUM_ALL, 1'b1, 1'b0, 1'b1, 1'b0);
    add_random_text(45);
    drain();

    repeat (2) begin
      apply_settings(tlnf_num_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      add_random_text(12);
      drain();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
